/* design/wbh_pkg.sv */
package wbh_pkg;

    // Field widths of the request and response beats
    localparam int HEAD_W = 16;
    localparam int LAT_W  = 31;
    localparam int LON_W  = 32;
    localparam int ABS_W  = 9;
    localparam int REL_W  = 17;

    // Angle accumulator: binary angle units, 2^32 per full turn
    localparam int ZW = 32;
    localparam logic [ZW-1:0] Z_QUARTER = 32'h4000_0000;
    localparam logic [ZW-1:0] Z_HALF    = 32'h8000_0000;

    // Heading remap constants
    localparam logic [ABS_W-1:0] HEAD_BASE   = 9'd270;
    localparam logic [ABS_W-1:0] FULL_CIRCLE = 9'd360;
    localparam int               HEAD_FRAC   = 7;

    // atan(2^-i) in binary angle units
    localparam logic [29:0] ATAN_TAB [32] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10680862,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5,
        30'd3,         30'd1,         30'd1,         30'd0
    };

    // Side information that rides along with each item
    typedef struct packed {
        logic [HEAD_W-1:0] cur;
        logic              xneg;
        logic              yneg;
        logic              zero;
    } side_t;

endpackage

/* design/wbh_if.sv */
interface wbh_req_if
    import wbh_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic [HEAD_W-1:0]        current_heading;
    logic signed [LAT_W-1:0]  here_lat;
    logic signed [LON_W-1:0]  here_lon;
    logic signed [LAT_W-1:0]  dest_lat;
    logic signed [LON_W-1:0]  dest_lon;

    modport source (
        output valid, current_heading, here_lat, here_lon, dest_lat, dest_lon,
        input  ready
    );
    modport sink (
        input  valid, current_heading, here_lat, here_lon, dest_lat, dest_lon,
        output ready
    );
endinterface

interface wbh_rsp_if
    import wbh_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic [ABS_W-1:0]         absolute_heading;
    logic signed [REL_W-1:0]  relative_heading;

    modport source (
        output valid, absolute_heading, relative_heading,
        input  ready
    );
    modport sink (
        input  valid, absolute_heading, relative_heading,
        output ready
    );
endinterface

/* design/wbh_cordic_stage.sv */
module wbh_cordic_stage
    import wbh_pkg::*;
#(
    parameter int CB    = 32,
    parameter int SHIFT = 0
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CB-1:0] x_in,
    input  logic signed [CB-1:0] y_in,
    input  logic signed [ZW-1:0] z_in,
    output logic signed [CB-1:0] x_out,
    output logic signed [CB-1:0] y_out,
    output logic signed [ZW-1:0] z_out
);

    localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_TAB[SHIFT]);

    logic signed [CB-1:0] x_reg, x_next;
    logic signed [CB-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic signed [CB-1:0] xs, ys;

    // Rotate toward the x axis by one micro-angle
    always_comb
    begin
        xs = x_in >>> SHIFT;
        ys = y_in >>> SHIFT;
        if (!y_in[CB-1])
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ANG;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ANG;
        end
    end

    // Load on advance, hold on stall
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

/* design/waypoint_bearing_to_heading.sv */
// Channel | Dir | Beat contents
// --------+-----+----------------------------------------------------------
// req     | in  | current_heading, here_lat, here_lon, dest_lat, dest_lon
// rsp     | out | absolute_heading, relative_heading
//
// One beat per cycle in and out while rsp is ready; the pipeline has
// 5 front stages (difference, magnitude, max, two normalize steps),
// one stage per CORDIC iteration and 4 back stages (clamp, scale, remap, offset).
// Reset (rst_n, async low) clears only the stage valid bits.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse and a stalled rsp holds its beat without loss or repeat.
module waypoint_bearing_to_heading
    import wbh_pkg::*;
#(
    parameter int CORDIC_STAGES = 16,
    parameter int COORD_BITS    = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    wbh_req_if.sink   req,
    wbh_rsp_if.source rsp
);

    localparam int CS = CORDIC_STAGES;
    localparam int CB = COORD_BITS;
    localparam int NW = (CB - 3 > 32) ? CB - 3 : 32;
    localparam int NS = $clog2(NW);
    localparam int NSPLIT = NS / 2;

    localparam int S_DIFF  = 0;
    localparam int S_ABS   = 1;
    localparam int S_MAX   = 2;
    localparam int S_NRM1  = 3;
    localparam int S_NRM2  = 4;
    localparam int S_COR0  = 5;
    localparam int S_CLAMP = S_COR0 + CS;
    localparam int S_MULT  = S_CLAMP + 1;
    localparam int S_HEAD  = S_MULT + 1;
    localparam int S_REL   = S_HEAD + 1;
    localparam int NST     = S_REL + 1;

    // Stage control
    logic [NST-1:0] v_reg, v_next;
    logic [NST:0]   en;
    side_t          side_reg [NST];
    side_t          side_next [NST];

    // Front datapath
    logic signed [LON_W:0]   dx_reg, dx_next;
    logic signed [LON_W-1:0] dy_reg, dy_next;
    logic [31:0]             ax_reg, ax_next, ay_reg, ay_next;
    logic [NW-1:0]           mx_reg, mx_next, my_reg, my_next, mm_reg, mm_next;
    logic [NW-1:0]           nx_reg, nx_next, ny_reg, ny_next, nm_reg, nm_next;
    logic [NW-1:0]           fx, fy, fm;
    logic signed [CB-1:0]    x0_reg, x0_next, y0_reg, y0_next;

    // CORDIC chain
    logic signed [CB-1:0] cx [CS+1];
    logic signed [CB-1:0] cy [CS+1];
    logic signed [ZW-1:0] cz [CS+1];

    // Back datapath
    logic [ZW-1:0]      zm_reg, zm_next;
    logic [30:0]        zc;
    logic [39:0]        prod;
    logic [7:0]         deg_reg, deg_next;
    logic [ABS_W-1:0]   hsum;
    logic [ABS_W-1:0]   h_reg, h_next;
    logic [ABS_W-1:0]   abs_reg, abs_next;
    logic [REL_W-1:0]   rel_reg, rel_next;

    // Advance chain: a stage loads when empty or when its successor loads
    always_comb
    begin
        en[NST] = rsp.ready;
        for (int s = NST - 1; s >= 0; s--)
        begin
            en[s] = !v_reg[s] || en[s+1];
        end
    end

    assign req.ready = en[0];

    always_comb
    begin
        v_next[0] = en[0] ? req.valid : v_reg[0];
        for (int s = 1; s < NST; s++)
        begin
            if (en[s])
            begin
                v_next[s] = v_reg[s-1];
            end
            else
            begin
                v_next[s] = v_reg[s];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // Side information: capture at entry, the signs at the magnitude stage, the zero vector at the max stage
    always_comb
    begin
        side_next[0].cur  = req.current_heading;
        side_next[0].xneg = 1'b0;
        side_next[0].yneg = 1'b0;
        side_next[0].zero = 1'b0;
        for (int s = 1; s < NST; s++)
        begin
            side_next[s] = side_reg[s-1];
        end
        side_next[S_ABS].xneg = dx_reg[LON_W];
        side_next[S_ABS].yneg = dy_reg[LON_W-1];
        side_next[S_MAX].zero = (mm_next == '0);
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NST; s++)
        begin
            if (en[s])
            begin
                side_reg[s] <= side_next[s];
            end
        end
    end

    // Exact coordinate differences
    assign dx_next = (LON_W+1)'(req.dest_lon) - (LON_W+1)'(req.here_lon);
    assign dy_next = LON_W'(req.dest_lat) - LON_W'(req.here_lat);

    // Magnitudes
    always_comb
    begin
        ax_next = dx_reg[LON_W] ? 32'(-dx_reg) : dx_reg[31:0];
        ay_next = dy_reg[LON_W-1] ? 32'(-dy_reg) : 32'(dy_reg);
    end

    // Larger magnitude drives normalization
    always_comb
    begin
        mx_next = NW'(ax_reg);
        my_next = NW'(ay_reg);
        mm_next = (ax_reg > ay_reg) ? NW'(ax_reg) : NW'(ay_reg);
    end

    // Normalize, coarse steps: shift left while the top K bits are clear
    always_comb
    begin
        nx_next = mx_reg;
        ny_next = my_reg;
        nm_next = mm_reg;
        for (int j = NS - 1; j >= NSPLIT; j--)
        begin
            if ((nm_next >> (NW - (1 << j))) == '0)
            begin
                nx_next = nx_next << (1 << j);
                ny_next = ny_next << (1 << j);
                nm_next = nm_next << (1 << j);
            end
        end
    end

    // Normalize, fine steps, then drop to leading bit at CB-4 (truncating)
    always_comb
    begin
        fx = nx_reg;
        fy = ny_reg;
        fm = nm_reg;
        for (int j = NSPLIT - 1; j >= 0; j--)
        begin
            if ((fm >> (NW - (1 << j))) == '0)
            begin
                fx = fx << (1 << j);
                fy = fy << (1 << j);
                fm = fm << (1 << j);
            end
        end
        x0_next = CB'(fx[NW-1:NW-CB+3]);
        y0_next = CB'(fy[NW-1:NW-CB+3]);
    end

    // Front stage registers
    always_ff @(posedge clk)
    begin
        if (en[S_DIFF])
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (en[S_ABS])
        begin
            ax_reg <= ax_next;
            ay_reg <= ay_next;
        end
        if (en[S_MAX])
        begin
            mx_reg <= mx_next;
            my_reg <= my_next;
            mm_reg <= mm_next;
        end
        if (en[S_NRM1])
        begin
            nx_reg <= nx_next;
            ny_reg <= ny_next;
            nm_reg <= nm_next;
        end
        if (en[S_NRM2])
        begin
            x0_reg <= x0_next;
            y0_reg <= y0_next;
        end
    end

    // CORDIC iterations, one register stage each
    assign cx[0] = x0_reg;
    assign cy[0] = y0_reg;
    assign cz[0] = '0;

    for (genvar k = 0; k < CS; k++)
    begin : g_cordic
        wbh_cordic_stage #(
            .CB    (CB),
            .SHIFT (k)
        ) u_stage (
            .clk   (clk),
            .en    (en[S_COR0 + k]),
            .x_in  (cx[k]),
            .y_in  (cy[k]),
            .z_in  (cz[k]),
            .x_out (cx[k+1]),
            .y_out (cy[k+1]),
            .z_out (cz[k+1])
        );
    end

    // Clamp to the first quadrant, mirror for a westward vector
    always_comb
    begin
        if (cz[CS][ZW-1])
        begin
            zc = '0;
        end
        else if (cz[CS] > $signed(Z_QUARTER))
        begin
            zc = Z_QUARTER[30:0];
        end
        else
        begin
            zc = cz[CS][30:0];
        end
        if (side_reg[S_CLAMP-1].xneg)
        begin
            zm_next = Z_HALF - ZW'(zc);
        end
        else
        begin
            zm_next = ZW'(zc);
        end
    end

    // Scale to degrees and round halves up; zero vector reads as 0
    always_comb
    begin
        prod = 40'(zm_reg) * 40'(FULL_CIRCLE) + 40'(Z_HALF);
        deg_next = side_reg[S_MULT-1].zero ? 8'd0 : prod[39:32];
    end

    // Remap to an absolute heading
    always_comb
    begin
        if (side_reg[S_HEAD-1].yneg)
        begin
            hsum = HEAD_BASE + ABS_W'(deg_reg);
            h_next = (hsum >= FULL_CIRCLE) ? hsum - FULL_CIRCLE : hsum;
        end
        else
        begin
            hsum = HEAD_BASE - ABS_W'(deg_reg);
            h_next = hsum;
        end
    end

    // Offset against the current heading, unwrapped
    always_comb
    begin
        abs_next = h_reg;
        rel_next = REL_W'({h_reg, HEAD_FRAC'(0)}) - REL_W'(side_reg[S_REL-1].cur);
    end

    // Back stage registers
    always_ff @(posedge clk)
    begin
        if (en[S_CLAMP])
        begin
            zm_reg <= zm_next;
        end
        if (en[S_MULT])
        begin
            deg_reg <= deg_next;
        end
        if (en[S_HEAD])
        begin
            h_reg <= h_next;
        end
        if (en[S_REL])
        begin
            abs_reg <= abs_next;
            rel_reg <= rel_next;
        end
    end

    assign rsp.valid            = v_reg[NST-1];
    assign rsp.absolute_heading = abs_reg;
    assign rsp.relative_heading = $signed(rel_reg);

`ifndef SYNTHESIS
    // An empty output stage frees the whole pipeline
    a_ready_when_out_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !v_reg[NST-1] |-> req.ready
    ) else $error("request blocked with an empty output stage");

    // Normalized vector has its leading bit exactly at CB-4
    a_norm_leading: assert property (
        @(posedge clk) disable iff (!rst_n)
        (v_reg[S_NRM2] && !side_reg[S_NRM2].zero)
            |-> ((x0_reg[CB-4] || y0_reg[CB-4]) && x0_reg[CB-1:CB-3] == '0
                 && y0_reg[CB-1:CB-3] == '0)
    ) else $error("CORDIC input not normalized");

    // Mirrored angle stays within a half turn
    a_half_turn: assert property (
        @(posedge clk) disable iff (!rst_n)
        v_reg[S_CLAMP] |-> (zm_reg <= Z_HALF)
    ) else $error("angle beyond half turn");

    // Zero vector maps to the heading base, as a due east vector does
    a_zero_vector: assert property (
        @(posedge clk) disable iff (!rst_n)
        (v_reg[S_HEAD] && side_reg[S_HEAD].zero) |-> (h_reg == HEAD_BASE)
    ) else $error("zero vector heading wrong");

    // Heading delivered is always below a full circle
    a_heading_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (abs_reg < FULL_CIRCLE)
    ) else $error("heading out of range");
`endif

endmodule

/* tb/wbh_heading_checker.sv */
`timescale 1ns / 100ps

module wbh_heading_checker
    import wbh_pkg::*;
#(
    parameter int CORDIC_STAGES = 16,
    parameter int COORD_BITS    = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    wbh_req_if        req,
    wbh_rsp_if        rsp,
    output int        fail_count,
    output int        outstanding
);

    localparam longint BASE_DEG  = 270;
    localparam longint TURN_DEG  = 360;
    localparam longint Z_QTR     = longint'(1) << 30;
    localparam longint Z_HLF     = longint'(1) << 31;

    typedef struct {
        logic [ABS_W-1:0]        abs_hdg;
        logic signed [REL_W-1:0] rel_hdg;
    } heading_t;

    // Predicted headings, oldest first
    heading_t heading_q[$];

    // Magnitude of atan2 in whole degrees (0..180), halves rounded up
    function automatic longint bearing_deg(input longint dx, input longint dy);
        longint ax;
        longint ay;
        longint mag;
        longint lim;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint step;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        mag = (ax > ay) ? ax : ay;
        if (mag == 0)
            return 0;
        lim = longint'(1) << (COORD_BITS - 3);
        // normalize the larger magnitude into [lim/2, lim)
        while (mag >= lim)
        begin
            ax = ax >>> 1;
            ay = ay >>> 1;
            mag = mag >>> 1;
        end
        while ((mag << 1) < lim)
        begin
            ax = ax << 1;
            ay = ay << 1;
            mag = mag << 1;
        end
        x = ax;
        y = ay;
        z = 0;
        // vectoring rotations drive y toward zero
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            xs = x >>> (i & 31);
            ys = y >>> (i & 31);
            step = longint'(ATAN_TAB[i & 31]);
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + step;
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - step;
            end
        end
        if (z < 0)
            z = 0;
        if (z > Z_QTR)
            z = Z_QTR;
        // mirror into the left half plane
        if (dx < 0)
            z = Z_HLF - z;
        return (z * TURN_DEG + Z_HLF) >>> 32;
    endfunction

    function automatic heading_t predict_heading(
        input logic [HEAD_W-1:0]       cur,
        input logic signed [LAT_W-1:0] hlat,
        input logic signed [LON_W-1:0] hlon,
        input logic signed [LAT_W-1:0] dlat,
        input logic signed [LON_W-1:0] dlon
    );
        longint dx;
        longint dy;
        longint ang;
        longint hdg;
        longint rel;
        heading_t r;
        dy = longint'(dlat) - longint'(hlat);
        dx = longint'(dlon) - longint'(hlon);
        ang = bearing_deg(dx, dy);
        if (dy < 0)
            ang = -ang;
        hdg = BASE_DEG - ang;
        if (hdg >= TURN_DEG)
            hdg = hdg - TURN_DEG;
        rel = hdg * 128 - longint'(cur);
        r.abs_hdg = hdg[ABS_W-1:0];
        r.rel_hdg = rel[REL_W-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        heading_t want;
        int bad;
        bad = 0;
        if (rst_n)
        begin
            // queue a prediction for each accepted request beat
            if (req.valid && req.ready)
                heading_q.push_back(predict_heading(req.current_heading, req.here_lat,
                                                    req.here_lon, req.dest_lat,
                                                    req.dest_lon));
            // compare each accepted response beat with the oldest prediction
            if (rsp.valid && rsp.ready)
            begin
                if (heading_q.size() == 0)
                begin
                    $error("response beat with no request pending: abs %0d rel %0d",
                           rsp.absolute_heading, rsp.relative_heading);
                    bad++;
                end
                else
                begin
                    want = heading_q.pop_front();
                    if (rsp.absolute_heading !== want.abs_hdg)
                    begin
                        $error("absolute_heading: expected %0d, actual %0d",
                               want.abs_hdg, rsp.absolute_heading);
                        bad++;
                    end
                    if (rsp.relative_heading !== want.rel_hdg)
                    begin
                        $error("relative_heading: expected %0d, actual %0d",
                               want.rel_hdg, rsp.relative_heading);
                        bad++;
                    end
                end
            end
        end
        fail_count <= fail_count + bad;
        outstanding <= heading_q.size();
    end

endmodule

/* tb/tb_waypoint_bearing_to_heading.sv */
`timescale 1ns / 100ps

module tb_waypoint_bearing_to_heading;
    import wbh_pkg::*;

    localparam int          STAGES     = 16;
    localparam int          CBITS      = 32;
    localparam int          LATENCY    = STAGES + 9;
    localparam int          NUM_RANDOM = 500;
    localparam int unsigned CYCLE_CAP  = 200000;
    localparam int unsigned HOLD_AT    = 500;
    localparam int unsigned HOLD_LEN   = 300;

    localparam longint LAT_MIN = -(longint'(1) << (LAT_W - 1));
    localparam longint LAT_MAX = (longint'(1) << (LAT_W - 1)) - 1;
    localparam longint LON_MIN = -(longint'(1) << (LON_W - 1));
    localparam longint LON_MAX = (longint'(1) << (LON_W - 1)) - 1;
    localparam longint GEO_LAT = 900000000;
    localparam longint GEO_LON = 1800000000;
    localparam longint HDG_MAX = 46079;

    typedef struct {
        logic [HEAD_W-1:0]       cur;
        logic signed [LAT_W-1:0] hlat;
        logic signed [LON_W-1:0] hlon;
        logic signed [LAT_W-1:0] dlat;
        logic signed [LON_W-1:0] dlon;
    } position_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    int unsigned cycles = 0;
    int unsigned beats_sent = 0;
    int          fail_count;
    int          outstanding;

    wbh_req_if req ();
    wbh_rsp_if rsp ();

    waypoint_bearing_to_heading #(
        .CORDIC_STAGES(STAGES),
        .COORD_BITS   (CBITS)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    wbh_heading_checker #(
        .CORDIC_STAGES(STAGES),
        .COORD_BITS   (CBITS)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Mostly no idle, sometimes a few cycles, rarely a long gap
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Offer one request beat and hold it until accepted
    task automatic send_beat(input position_t p);
        int unsigned gap;
        gap = ((beats_sent % 64) < 16) ? 0 : idle_len();
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid           <= 1'b1;
        req.current_heading <= p.cur;
        req.here_lat        <= p.hlat;
        req.here_lon        <= p.hlon;
        req.dest_lat        <= p.dlat;
        req.dest_lon        <= p.dlon;
        do
            @(posedge clk);
        while (!req.ready);
        beats_sent++;
    endtask

    task automatic send_pos(input longint cur, input longint hlat, input longint hlon,
                            input longint dlat, input longint dlon);
        position_t p;
        p.cur  = cur[HEAD_W-1:0];
        p.hlat = hlat[LAT_W-1:0];
        p.hlon = hlon[LON_W-1:0];
        p.dlat = dlat[LAT_W-1:0];
        p.dlon = dlon[LON_W-1:0];
        send_beat(p);
    endtask

    function automatic longint rand_span(input longint lim);
        return longint'($urandom_range(0, 32'(2 * lim))) - lim;
    endfunction

    function automatic longint rand_delta();
        int unsigned roll;
        roll = $urandom_range(0, 3);
        if (roll == 0)
            return longint'($urandom_range(0, 6)) - 3;
        if (roll == 1)
            return longint'($urandom_range(0, 2000)) - 1000;
        return longint'($urandom_range(0, 2000000)) - 1000000;
    endfunction

    // Random position pair drawn from one of several shapes
    task automatic send_random();
        longint cur;
        longint hlat;
        longint hlon;
        longint dlat;
        longint dlon;
        int unsigned kind;
        cur = ($urandom_range(0, 9) == 0) ? longint'($urandom_range(0, 65535))
                                          : longint'($urandom_range(0, HDG_MAX));
        hlat = rand_span(GEO_LAT);
        hlon = rand_span(GEO_LON);
        kind = $urandom_range(0, 99);
        if (kind < 35)
        begin
            // anywhere on the globe
            dlat = rand_span(GEO_LAT);
            dlon = rand_span(GEO_LON);
        end
        else if (kind < 65)
        begin
            // nearby target
            dlat = hlat + rand_delta();
            dlon = hlon + rand_delta();
        end
        else if (kind < 77)
        begin
            // along one axis
            dlat = hlat;
            dlon = hlon;
            if ($urandom_range(0, 1))
                dlat = hlat + rand_delta();
            else
                dlon = hlon + rand_delta();
        end
        else if (kind < 87)
        begin
            // exact diagonal, including mirrored quadrants
            dlat = rand_delta();
            dlon = ($urandom_range(0, 1)) ? dlat : -dlat;
            dlat = hlat + dlat;
            dlon = hlon + dlon;
        end
        else
        begin
            // any bit pattern of the fields
            hlat = longint'($urandom());
            hlon = longint'($urandom());
            dlat = longint'($urandom());
            dlon = longint'($urandom());
        end
        send_pos(cur, hlat, hlon, dlat, dlon);
    endtask

    // Response side: random stalls plus one long hold-off
    initial
    begin
        int unsigned run;
        int unsigned stall;
        bit          held;
        held = 1'b0;
        rsp.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            rsp.ready <= 1'b1;
            repeat (run) @(posedge clk);
            if (!held && cycles >= HOLD_AT)
            begin
                held = 1'b1;
                rsp.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
            end
            else
            begin
                stall = idle_len();
                if (stall != 0)
                begin
                    rsp.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        req.valid           <= 1'b0;
        req.current_heading <= '0;
        req.here_lat        <= '0;
        req.here_lon        <= '0;
        req.dest_lat        <= '0;
        req.dest_lon        <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero vector, then the four axis directions
        send_pos(0, 0, 0, 0, 0);
        send_pos(HDG_MAX, 0, 0, 0, 1000);
        send_pos(65535, 0, 1000, 0, 0);
        send_pos(0, 0, 0, 1000, 0);
        send_pos(128, 0, 0, -1000, 0);
        // diagonals in every quadrant
        send_pos(11520, 0, 0, 500, 500);
        send_pos(23040, 0, 0, 500, -500);
        send_pos(34560, 0, 0, -500, -500);
        send_pos(1, 0, 0, -500, 500);
        // unit differences need the largest left shift
        send_pos(0, 7, 7, 7, 8);
        send_pos(HDG_MAX, 7, 7, 8, 6);
        send_pos(65535, 7, 7, 6, 7);
        // full-width differences need a right shift
        send_pos(0, LAT_MIN, LON_MAX, LAT_MAX, LON_MIN);
        send_pos(HDG_MAX, LAT_MAX, LON_MIN, LAT_MIN, LON_MAX);
        send_pos(65535, LAT_MIN, LON_MIN, LAT_MAX, LON_MAX);
        send_pos(0, LAT_MAX, LON_MAX, LAT_MIN, LON_MIN);
        // geographic extremes
        send_pos(HDG_MAX, -GEO_LAT, -GEO_LON, GEO_LAT, GEO_LON);
        send_pos(0, GEO_LAT, GEO_LON, -GEO_LAT, -GEO_LON);
        // just off the negative x axis: rounds to a half turn on either side
        send_pos(0, 1, LON_MAX, 0, LON_MIN);
        send_pos(65535, 0, LON_MAX, 1, LON_MIN);
        // just off the positive x axis
        send_pos(HDG_MAX, 0, LON_MIN, -1, LON_MAX);
        send_pos(0, -1, LON_MIN, 0, LON_MAX);

        for (int n = 0; n < NUM_RANDOM; n++)
            send_random();
        req.valid <= 1'b0;

        // let the count of pending beats take in the last accepted one
        @(posedge clk);

        // drain the pipeline, then wait out its latency
        while (outstanding != 0)
            @(posedge clk);
        repeat (LATENCY + 16) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
